// File: design/tle_pkg.sv
// Shared types and constants for the terminal line editor.
package tle_pkg;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CHAR_W    = 8;
	localparam int ECHO_W    = 7;
	localparam int COUNT_W   = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ERASE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_ERASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KILL       = 2'd2;

	localparam logic [CFG_W-1:0] ERASE_RST      = 7'd127;
	localparam logic [CFG_W-1:0] WORD_ERASE_RST = 7'd23;
	localparam logic [CFG_W-1:0] KILL_RST       = 7'd21;

	localparam logic [CHAR_W-1:0] CTRL_D     = 8'h04;
	localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;
	localparam logic [ECHO_W-1:0] SPACE_CHAR = 7'h20;

	typedef enum logic [2:0] {
		KIND_ECHO  = 3'd0,
		KIND_ERASE = 3'd1,
		KIND_CLEAR = 3'd2,
		KIND_BELL  = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CLS_PRINT,
		CLS_ERASE,
		CLS_WERASE,
		CLS_KILL,
		CLS_EOF,
		CLS_BELL,
		CLS_IGNORE
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic walk_init;
		logic walk_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_werase;
		logic has_result;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

// File: design/tle_ctrl.sv
// Sequencing state machine for the line editor.
module tle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tle_pkg::sts_t sts,
	output tle_pkg::cmd_t cmd
);
	import tle_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				state_nxt = sts.is_werase ? ST_WALK : ST_EMIT;
			end
			ST_WALK: begin
				if (sts.walk_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.has_result || sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CLASSIFY: begin
				cmd.walk_init = sts.is_werase;
			end
			ST_WALK: begin
				cmd.walk_step = !sts.walk_done;
			end
			ST_EMIT: begin
				cmd.commit = !sts.has_result || sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: design/tle_dp.sv
// Datapath: control registers, line store, word-erase walker and result register.
module tle_dp #(
	parameter int LINE_LENGTH = 40
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tle_pkg::cmd_t                      cmd,
	output tle_pkg::sts_t                      sts,
	input  logic [tle_pkg::CHAR_W-1:0]         char_in,
	input  logic                               cfg_we,
	input  logic [tle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tle_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         kind,
	output logic [tle_pkg::ECHO_W-1:0]         echo_char,
	output logic [tle_pkg::COUNT_W-1:0]        erase_count,
	output logic                               newline_before
);
	import tle_pkg::*;

	localparam int LEN_W  = $clog2(LINE_LENGTH + 1);
	localparam int ADDR_W = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_LENGTH);

	// control registers
	logic [CFG_W-1:0] erase_q, werase_q, kill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q  <= ERASE_RST;
			werase_q <= WORD_ERASE_RST;
			kill_q   <= KILL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERASE:      erase_q  <= cfg_wdata;
				REG_WORD_ERASE: werase_q <= cfg_wdata;
				REG_KILL:       kill_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request byte
	logic [CHAR_W-1:0] char_q;

	always_ff @(posedge clk) begin
		if (cmd.load) char_q <= char_in;
	end

	logic [LEN_W-1:0] len_q, walk_q;
	logic             ended_q, phase_q;
	cls_t             cls;

	always_comb begin
		priority if (ended_q)                                  cls = CLS_IGNORE;
		else if (char_q >= PRINT_LO && char_q <= PRINT_HI)     cls = CLS_PRINT;
		else if (!char_q[CHAR_W-1] && char_q[CFG_W-1:0] == erase_q)  cls = CLS_ERASE;
		else if (!char_q[CHAR_W-1] && char_q[CFG_W-1:0] == werase_q) cls = CLS_WERASE;
		else if (!char_q[CHAR_W-1] && char_q[CFG_W-1:0] == kill_q)   cls = CLS_KILL;
		else if (char_q == CTRL_D)                             cls = CLS_EOF;
		else                                                   cls = CLS_BELL;
	end

	// line store, registered read
	logic [ECHO_W-1:0] mem [LINE_LENGTH];
	logic [ECHO_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              line_full;

	assign line_full = (len_q >= LEN_FULL);
	assign wr_addr   = line_full ? '0 : len_q[ADDR_W-1:0];

	// word-erase walker: phase 0 skips spaces, phase 1 skips the word
	logic             rd_space, walk_done, walk_dec;
	logic [LEN_W-1:0] walk_nxt, rd_n_m1, dropped;

	assign rd_space  = (rd_data_q == SPACE_CHAR);
	assign walk_done = (walk_q == '0) || (phase_q && rd_space);
	assign walk_dec  = cmd.walk_step && !walk_done && (rd_space != phase_q);

	always_comb begin
		if (cmd.walk_init)  walk_nxt = len_q;
		else if (walk_dec)  walk_nxt = walk_q - 1'b1;
		else                walk_nxt = walk_q;
	end

	assign rd_n_m1 = walk_nxt - 1'b1;
	assign rd_addr = rd_n_m1[ADDR_W-1:0];
	assign dropped = len_q - walk_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && cls == CLS_PRINT) mem[wr_addr] <= char_q[ECHO_W-1:0];
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			walk_q <= walk_nxt;
			if (cmd.walk_init) begin
				phase_q <= 1'b0;
			end else if (cmd.walk_step && !walk_done && !phase_q && !rd_space) begin
				phase_q <= 1'b1;
			end
		end
	end

	// line state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ended_q <= 1'b0;
		end else if (cmd.commit) begin
			unique case (cls)
				CLS_PRINT:  len_q <= line_full ? LEN_W'(1) : len_q + 1'b1;
				CLS_ERASE:  if (len_q != '0) len_q <= len_q - 1'b1;
				CLS_WERASE: len_q <= walk_q;
				CLS_KILL:   len_q <= '0;
				CLS_EOF:    if (len_q == '0) ended_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result formation
	logic                   has_result;
	kind_t                  res_kind;
	logic [ECHO_W-1:0]      res_char;
	logic [COUNT_W-1:0]     res_cnt;
	logic                   res_nl;
	logic [LEN_W+COUNT_W-1:0] dropped_ext;

	assign dropped_ext = (LEN_W + COUNT_W)'(dropped);

	always_comb begin
		has_result = 1'b1;
		res_kind   = KIND_BELL;
		res_char   = '0;
		res_cnt    = '0;
		res_nl     = 1'b0;
		unique case (cls)
			CLS_PRINT: begin
				res_kind = KIND_ECHO;
				res_char = char_q[ECHO_W-1:0];
				res_nl   = line_full;
			end
			CLS_ERASE: begin
				res_kind   = KIND_ERASE;
				res_cnt    = COUNT_W'(1);
				has_result = (len_q != '0);
			end
			CLS_WERASE: begin
				res_kind   = KIND_ERASE;
				res_cnt    = dropped_ext[COUNT_W-1:0];
				has_result = (dropped != '0);
			end
			CLS_KILL:   res_kind = KIND_CLEAR;
			CLS_EOF: begin
				res_kind   = KIND_END;
				has_result = (len_q == '0);
			end
			CLS_BELL:   res_kind = KIND_BELL;
			default:    has_result = 1'b0;
		endcase
	end

	// output register
	logic                out_valid_q, out_free, out_load;
	kind_t               kind_q;
	logic [ECHO_W-1:0]   echo_q;
	logic [COUNT_W-1:0]  count_q;
	logic                nl_q;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = cmd.commit && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q  <= res_kind;
			echo_q  <= res_char;
			count_q <= res_cnt;
			nl_q    <= res_nl;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign echo_char      = echo_q;
	assign erase_count    = count_q;
	assign newline_before = nl_q;

	assign sts.is_werase  = (cls == CLS_WERASE);
	assign sts.has_result = has_result;
	assign sts.walk_done  = walk_done;
	assign sts.out_free   = out_free;

endmodule

// File: design/terminal_line_editor.sv
// Top level of the terminal line editor: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | char_in
//  output   | out_valid / out_stall| kind, echo_char, erase_count, newline_before
//  config   | cfg_we               | cfg_index, cfg_wdata
//
// One request at a time. A request passes through accept, classify and
// commit; word erase adds a walk over the line store, through its single
// registered read port, between classify and commit.
// Reset clears the line length, the end-of-input flag and the result
// register; control registers return to their defaults. The line store is
// not cleared: only entries below the line length are ever read.
// A stalled output holds its result; the next request is still taken and
// waits at commit only if it too has a result while the register is full.
module terminal_line_editor #(
	parameter int LINE_LENGTH = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tle_pkg::CHAR_W-1:0]    char_in,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    kind,
	output logic [tle_pkg::ECHO_W-1:0]    echo_char,
	output logic [tle_pkg::COUNT_W-1:0]   erase_count,
	output logic                          newline_before,
	// control register writes
	input  logic                          cfg_we,
	input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tle_pkg::CFG_W-1:0]     cfg_wdata
);
	import tle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, classify, walk (word erase only), commit
	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, decode, walker and result register
	tle_dp #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.char_in        (char_in),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.echo_char      (echo_char),
		.erase_count    (erase_count),
		.newline_before (newline_before)
	);

endmodule

// File: bench/tle_screen_checker.sv
// Screen action checker for the terminal line editor: predicts each result and compares it.
`timescale 1ns / 100ps
module tle_screen_checker #(
	parameter int LINE_LENGTH = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tle_pkg::CHAR_W-1:0]    char_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [2:0]                    kind,
	input  logic [tle_pkg::ECHO_W-1:0]    echo_char,
	input  logic [tle_pkg::COUNT_W-1:0]   erase_count,
	input  logic                          newline_before,
	input  logic                          cfg_we,
	input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tle_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            mismatches,
	output int                            results_due
);
	import tle_pkg::*;

	typedef struct {
		kind_t               kind;
		logic [ECHO_W-1:0]   echo;
		logic [COUNT_W-1:0]  count;
		logic                nl;
	} screen_action_t;

	screen_action_t      expected_actions [$];
	logic [ECHO_W-1:0]   line_buf [LINE_LENGTH];
	int                  line_len;
	bit                  input_done;
	logic [CFG_W-1:0]    erase_key;
	logic [CFG_W-1:0]    werase_key;
	logic [CFG_W-1:0]    kill_key;
	int                  bad;

	task automatic post(input kind_t k, input logic [ECHO_W-1:0] ch,
			input logic [COUNT_W-1:0] cnt, input logic nl);
		screen_action_t a;
		a.kind  = k;
		a.echo  = ch;
		a.count = cnt;
		a.nl    = nl;
		expected_actions.push_back(a);
	endtask

	task automatic edit_line(input logic [CHAR_W-1:0] key);
		int   n;
		logic nl;
		if (input_done) begin
			// input has ended: nothing more is produced
		end else if (key >= PRINT_LO && key <= PRINT_HI) begin
			nl = (line_len >= LINE_LENGTH);
			if (nl)
				line_len = 0;
			line_buf[line_len] = key[ECHO_W-1:0];
			line_len++;
			post(KIND_ECHO, key[ECHO_W-1:0], '0, nl);
		end else if (key == {1'b0, erase_key}) begin
			if (line_len > 0) begin
				line_len--;
				post(KIND_ERASE, '0, COUNT_W'(1), 1'b0);
			end
		end else if (key == {1'b0, werase_key}) begin
			// trailing spaces first, then the word before them
			n = line_len;
			while (n > 0 && line_buf[n-1] == SPACE_CHAR)
				n--;
			while (n > 0 && line_buf[n-1] != SPACE_CHAR)
				n--;
			if (n != line_len)
				post(KIND_ERASE, '0, COUNT_W'(line_len - n), 1'b0);
			line_len = n;
		end else if (key == {1'b0, kill_key}) begin
			line_len = 0;
			post(KIND_CLEAR, '0, '0, 1'b0);
		end else if (key == CTRL_D) begin
			if (line_len == 0) begin
				input_done = 1'b1;
				post(KIND_END, '0, '0, 1'b0);
			end
		end else begin
			post(KIND_BELL, '0, '0, 1'b0);
		end
	endtask

	task automatic compare_result();
		screen_action_t a;
		if (expected_actions.size() == 0) begin
			$error("unexpected result: kind %0d echo_char %0h erase_count %0d",
				kind, echo_char, erase_count);
			bad++;
		end else begin
			a = expected_actions.pop_front();
			if (kind !== a.kind) begin
				$error("kind: expected %0d, got %0d", a.kind, kind);
				bad++;
			end
			if (echo_char !== a.echo) begin
				$error("echo_char: expected %0h, got %0h", a.echo, echo_char);
				bad++;
			end
			if (erase_count !== a.count) begin
				$error("erase_count: expected %0d, got %0d", a.count, erase_count);
				bad++;
			end
			if (newline_before !== a.nl) begin
				$error("newline_before: expected %0b, got %0b", a.nl, newline_before);
				bad++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_actions.delete();
			line_len   = 0;
			input_done = 1'b0;
			erase_key  = ERASE_RST;
			werase_key = WORD_ERASE_RST;
			kill_key   = KILL_RST;
			bad        = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (cfg_we) begin
				case (cfg_index)
					REG_ERASE:      erase_key  = cfg_wdata;
					REG_WORD_ERASE: werase_key = cfg_wdata;
					REG_KILL:       kill_key   = cfg_wdata;
					default:        ;
				endcase
			end
			if (in_valid && !in_stall)
				edit_line(char_in);
		end
		// published with NBAs so the stimulus side samples settled values
		mismatches  <= bad;
		results_due <= expected_actions.size();
	end

endmodule

// File: bench/terminal_line_editor_tb.sv
// Testbench top for the terminal line editor: reset, key stimulus, flow control and verdict.
`timescale 1ns / 100ps
module terminal_line_editor_tb;
	import tle_pkg::*;

	localparam int LINE_LENGTH   = 40;
	localparam int PHASE_ITEMS   = 215;
	localparam int NUM_PHASES    = 8;
	localparam int FIXED_SETS    = 6;
	localparam int HOLD_PHASE    = 2;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_ITEMS    = 30;
	// worst request is a word erase over a full line
	localparam int SETTLE_CYCLES = LINE_LENGTH + 20;
	localparam int CYCLE_LIMIT   = 800_000;
	localparam int OPENING_COUNT = 23;

	// index past the last control register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [CHAR_W-1:0] NUL_KEY    = 8'h00;
	localparam logic [CHAR_W-1:0] BEL_KEY    = 8'h07;
	localparam logic [CHAR_W-1:0] LAST_CTRL  = 8'h1F;
	localparam logic [CHAR_W-1:0] DEL_KEY    = 8'h7F;
	localparam logic [CHAR_W-1:0] HIGH_LO    = 8'h80;
	localparam logic [CHAR_W-1:0] HIGH_HI    = 8'hFF;
	localparam logic [CHAR_W-1:0] LETTER_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] LETTER_HI  = 8'h7A;
	localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
	localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_B    = 8'h62;
	localparam logic [CHAR_W-1:0] LOWER_C    = 8'h63;
	localparam logic [CHAR_W-1:0] DEF_ERASE  = {1'b0, ERASE_RST};
	localparam logic [CHAR_W-1:0] DEF_WERASE = {1'b0, WORD_ERASE_RST};
	localparam logic [CHAR_W-1:0] DEF_KILL   = {1'b0, KILL_RST};

	// Opening sequence under the reset keys. Notes on what each group hits:
	//   erase / word erase on an empty line (silent), kill on an empty line,
	//   bell on both ends of the control range and on high bytes,
	//   word erase of a line holding only spaces, Ctrl-D with text on the line,
	//   word erase through trailing spaces, single erase, word erase of a word.
	localparam logic [CHAR_W-1:0] OPENING_KEYS [OPENING_COUNT] = '{
		DEF_ERASE, DEF_WERASE, DEF_KILL,
		NUL_KEY, LAST_CTRL, HIGH_LO, HIGH_HI,
		PRINT_LO, PRINT_LO, DEF_WERASE,
		PRINT_HI, CTRL_D,
		LOWER_A, PRINT_LO, PRINT_LO, DEF_WERASE,
		UPPER_A, DEF_ERASE,
		LOWER_B, PRINT_LO, LOWER_C, DEF_WERASE,
		DEF_KILL
	};

	// Key settings per phase: defaults, backspace, extremes with kill on Ctrl-D,
	// all three equal (priority), all printable (controls shadowed), swapped.
	localparam logic [CFG_W-1:0] ERASE_SET  [FIXED_SETS] =
		'{7'd127, 7'd8, 7'd0, 7'd4, 7'h41, 7'd23};
	localparam logic [CFG_W-1:0] WERASE_SET [FIXED_SETS] =
		'{7'd23, 7'd23, 7'd127, 7'd4, 7'h20, 7'd8};
	localparam logic [CFG_W-1:0] KILL_SET   [FIXED_SETS] =
		'{7'd21, 7'd21, 7'd4, 7'd4, 7'h7E, 7'd0};

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [CHAR_W-1:0]    char_in        = '0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [2:0]           kind;
	logic [ECHO_W-1:0]    echo_char;
	logic [COUNT_W-1:0]   erase_count;
	logic                 newline_before;
	logic                 cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_wdata      = '0;
	int                   mismatches;
	int                   results_due;
	int                   cycle_count    = 0;

	// stimulus-side copy of the keys, used to pick control bytes
	logic [CFG_W-1:0]     erase_key      = ERASE_RST;
	logic [CFG_W-1:0]     werase_key     = WORD_ERASE_RST;
	logic [CFG_W-1:0]     kill_key       = KILL_RST;

	// idle gaps on/off per side; hold_req asks the receiver for one long hold
	bit                   tx_idle        = 1'b1;
	bit                   rx_idle        = 1'b1;
	bit                   hold_req       = 1'b0;

	terminal_line_editor #(.LINE_LENGTH(LINE_LENGTH)) DUT (.*);

	tle_screen_checker #(.LINE_LENGTH(LINE_LENGTH)) u_checker (.*);

	always #5 clk = ~clk;

	// watchdog: a hung handshake or a missing result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[terminal_line_editor] ERROR");
			$finish;
		end
	end

	function automatic logic [CHAR_W-1:0] rand_letter();
		return CHAR_W'($urandom_range(LETTER_LO, LETTER_HI));
	endfunction

	// Keys mostly in the control range, where they actually act.
	function automatic logic [CFG_W-1:0] rand_key();
		return CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 127));
	endfunction

	// One request: optional idle gap with valid low, then hold the byte until
	// taken. A back-to-back request keeps valid high with a single NBA.
	task automatic send_char(input logic [CHAR_W-1:0] key);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= key;
		do @(posedge clk); while (in_stall);
	endtask

	// Sender pause: wait out every expected result, then give a request that
	// produces nothing time to finish its walk before touching the keys.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_keys(input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] k);
		write_reg(REG_ERASE, e);
		write_reg(REG_WORD_ERASE, w);
		write_reg(REG_KILL, k);
		cfg_we     <= 1'b0;
		erase_key  = e;
		werase_key = w;
		kill_key   = k;
	endtask

	// Random typing: mostly words and spaces so lines grow, get edited and
	// wrap; the rest is control keys, stray control bytes and high bytes.
	// Ctrl-D only ever follows a printable byte, so the line is never empty
	// and input cannot end before the closing sequence.
	task automatic run_phase(input int count);
		int                sent;
		int                roll;
		int                n;
		int                next_mix;
		logic [CHAR_W-1:0] noise;
		sent     = 0;
		next_mix = 0;
		while (sent < count) begin
			if (sent >= next_mix) begin
				tx_idle  = ($urandom_range(0, 3) != 0);
				rx_idle  = ($urandom_range(0, 3) != 0);
				next_mix = sent + 64;
			end
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				// long run that fills the line and wraps it
				n = $urandom_range(LINE_LENGTH + 1, LINE_LENGTH + 10);
				repeat (n) send_char(($urandom_range(0, 9) == 0) ? PRINT_LO : rand_letter());
				sent += n;
			end else if (roll < 47) begin
				send_char(rand_letter());
			end else if (roll < 62) begin
				send_char(PRINT_LO);
			end else if (roll < 66) begin
				send_char(CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)));
			end else if (roll < 74) begin
				send_char({1'b0, erase_key});
			end else if (roll < 83) begin
				send_char({1'b0, werase_key});
			end else if (roll < 86) begin
				send_char({1'b0, kill_key});
			end else if (roll < 90) begin
				send_char(rand_letter());
				send_char(CTRL_D);
				sent++;
			end else if (roll < 95) begin
				n     = $urandom_range(0, 32);
				noise = (n == 32) ? DEL_KEY : CHAR_W'(n);
				send_char((noise == CTRL_D) ? BEL_KEY : noise);
			end else begin
				send_char(CHAR_W'($urandom_range(HIGH_LO, HIGH_HI)));
			end
			sent++;
		end
	endtask

	// Receiver: random stall before each result, plus one long hold on request
	// so the result register and the commit stage back up into in_stall.
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			n = rx_idle ? $urandom_range(0, 15) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int p;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < OPENING_COUNT; i++)
			send_char(OPENING_KEYS[i]);

		// full line of one word: word erase takes all of it, then a wrap
		repeat (LINE_LENGTH) send_char(rand_letter());
		send_char(DEF_WERASE);
		repeat (LINE_LENGTH + 1) send_char(rand_letter());
		send_char(DEF_KILL);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			if (p == 0)
				write_reg(REG_UNUSED, CFG_W'($urandom));
			if (p < FIXED_SETS)
				set_keys(ERASE_SET[p], WERASE_SET[p], KILL_SET[p]);
			else
				set_keys(rand_key(), rand_key(), rand_key());
			if (p == HOLD_PHASE) begin
				run_phase(PHASE_ITEMS / 2);
				// every letter echoes, so these pile up behind the held output
				hold_req = 1'b1;
				repeat (HOLD_ITEMS) send_char(rand_letter());
				run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				run_phase(PHASE_ITEMS);
			end
		end

		// Closing: empty the line, end input, then bytes that must be ignored.
		drain();
		set_keys(ERASE_RST, WORD_ERASE_RST, KILL_RST);
		send_char(DEF_KILL);
		send_char(CTRL_D);
		repeat (12) send_char(CHAR_W'($urandom));
		drain();

		if (mismatches == 0 && results_due == 0) begin
			$display("[terminal_line_editor] OK");
		end else begin
			$display("[terminal_line_editor] ERROR");
		end
		$finish;
	end

endmodule
